### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: request and
// result payloads, action codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

   localparam int OWNER_W  = 8;
   localparam int SIZE_W   = 16;
   localparam int INDEX_W  = 9;
   localparam int OFFSET_W = 15;
   // wide enough for any block index plus any skip or request in blocks
   localparam int SUM_W    = 17;

   localparam logic [OWNER_W-1:0] FREE_MARK = 8'hFF;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_SIZE  = 2'd1;
   localparam logic [1:0] ACT_OWNER = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [OWNER_W-1:0]  owner_id;
      logic [SIZE_W-1:0]   byte_size;
      logic [INDEX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator of contiguous blocks over an owner table, with a
// per-owner size table used to skip occupied runs.
// ----------------------------------------------------------------------------
// Size and owner table writes go straight to the done state on acceptance.
// An allocation walks the owner table one entry at a time, looks up the size
// table to skip the run of each occupied entry with a sized owner, and marks
// each block of the chosen run; the serial walk of the owner table RAM sets
// its length. One item at a time; the next item is taken in the cycle after
// the previous result moves into the output register.
// Reset: a clearing pass frees every block and zeroes every size; req_ready
// stays low until it ends.
`default_nettype none

module first_fit_block_allocator #(
   parameter int NUM_BLOCKS  = 512,
   parameter int NUM_OWNERS  = 96,
   parameter int BLOCK_SHIFT = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffba_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffba_pkg::rsp_type      rsp_data
);

   import ffba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int OW = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;

   // sequencer to output register
   logic              res_valid;
   logic              res_ready;
   rsp_type           res_data;

   // owner table RAM port
   logic              own_we;
   logic [AW-1:0]     own_waddr;
   logic [7:0]        own_wdata;
   logic [AW-1:0]     own_raddr;
   logic [7:0]        own_rdata;

   // size table RAM port
   logic              sz_we;
   logic [OW-1:0]     sz_waddr;
   logic [15:0]       sz_wdata;
   logic [OW-1:0]     sz_raddr;
   logic [15:0]       sz_rdata;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   ffba_seq #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .NUM_OWNERS  (NUM_OWNERS),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .own_we    (own_we),
      .own_waddr (own_waddr),
      .own_wdata (own_wdata),
      .own_raddr (own_raddr),
      .own_rdata (own_rdata),
      .sz_we     (sz_we),
      .sz_waddr  (sz_waddr),
      .sz_wdata  (sz_wdata),
      .sz_raddr  (sz_raddr),
      .sz_rdata  (sz_rdata)
   );

   // owner table: one entry per block, FREE_MARK when free
   ffba_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (8)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (own_raddr),
      .rd_data (own_rdata)
   );

   // size table: recorded byte size per owner id
   ffba_ram #(
      .DEPTH (NUM_OWNERS),
      .WIDTH (16)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (sz_we),
      .wr_addr (sz_waddr),
      .wr_data (sz_wdata),
      .rd_addr (sz_raddr),
      .rd_data (sz_rdata)
   );

   // hand over a result whenever the output register is empty or draining
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the item until taken; load a fresh one on handover
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/ffba_seq.sv
// ----------------------------------------------------------------------------
// ffba_seq
// Allocation sequencer: clears both tables after reset, decodes items, walks
// the owner table one entry per cycle or by a size skip; marks the chosen run.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_seq #(
   parameter int NUM_BLOCKS  = 512,
   parameter int NUM_OWNERS  = 96,
   parameter int BLOCK_SHIFT = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ffba_pkg::req_type    req_data,
   output logic                      res_valid,
   input  wire logic                 res_ready,
   output ffba_pkg::rsp_type         res_data,
   output logic                      own_we,
   output logic [$clog2(NUM_BLOCKS)-1:0] own_waddr,
   output logic [7:0]                own_wdata,
   output logic [$clog2(NUM_BLOCKS)-1:0] own_raddr,
   input  wire logic [7:0]           own_rdata,
   output logic                      sz_we,
   output logic [(NUM_OWNERS > 1 ? $clog2(NUM_OWNERS) : 1)-1:0] sz_waddr,
   output logic [15:0]               sz_wdata,
   output logic [(NUM_OWNERS > 1 ? $clog2(NUM_OWNERS) : 1)-1:0] sz_raddr,
   input  wire logic [15:0]          sz_rdata
);

   import ffba_pkg::*;

   localparam int AW     = $clog2(NUM_BLOCKS);
   localparam int OW     = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
   localparam int CLR_N  = (NUM_BLOCKS > NUM_OWNERS) ? NUM_BLOCKS : NUM_OWNERS;
   localparam int CW     = $clog2(CLR_N);
   localparam int WIDE_W = AW + BLOCK_SHIFT + OFFSET_W;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_RUN   = 7'b0001000,
      ST_SIZE  = 7'b0010000,
      ST_MARK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   function automatic logic [OFFSET_W-1:0] offset_of(input logic [AW-1:0] blk);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(blk) << BLOCK_SHIFT;
      return wide[OFFSET_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [CW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         start_ff, start_in;
   logic [SUM_W-1:0]      end_ff, end_in;
   logic [SIZE_W-1:0]     need_ff, need_in;
   logic [OWNER_W-1:0]    id_ff, id_in;
   logic                  ok_ff, ok_in;
   logic [OFFSET_W-1:0]   off_ff, off_in;

   logic [SUM_W-1:0]      idx_inc;
   logic [SUM_W-1:0]      idx_skip;
   logic [SIZE_W-1:0]     skip_blk;
   logic                  inc_past;
   logic                  own_free;
   logic                  own_sized;

   assign idx_inc   = SUM_W'(idx_ff) + SUM_W'(1);
   assign inc_past  = idx_inc >= SUM_W'(NUM_BLOCKS);
   assign own_free  = own_rdata == FREE_MARK;
   assign own_sized = own_rdata < OWNER_W'(NUM_OWNERS);
   assign skip_blk  = ((sz_rdata >> BLOCK_SHIFT) == '0) ? SIZE_W'(1)
                                                         : (sz_rdata >> BLOCK_SHIFT);
   assign idx_skip  = SUM_W'(idx_ff) + SUM_W'(skip_blk);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      idx_in    = idx_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      need_in   = need_ff;
      id_in     = id_ff;
      ok_in     = ok_ff;
      off_in    = off_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res_data  = '{ok: ok_ff, byte_offset: off_ff};
      own_we    = 1'b0;
      own_waddr = idx_ff;
      own_wdata = id_ff;
      sz_we     = 1'b0;
      sz_waddr  = OW'(req_data.owner_id);
      sz_wdata  = req_data.byte_size;
      sz_raddr  = OW'(own_rdata);

      unique case (state_ff) inside
         ST_CLEAR: begin
            own_we    = 32'(clr_ff) < NUM_BLOCKS;
            own_waddr = AW'(clr_ff);
            own_wdata = FREE_MARK;
            sz_we     = 32'(clr_ff) < NUM_OWNERS;
            sz_waddr  = OW'(clr_ff);
            sz_wdata  = '0;
            clr_in    = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ok_in    = 1'b0;
               off_in   = '0;
               state_in = ST_DONE;
               unique case (req_data.action)
                  ACT_ALLOC: begin
                     if (req_data.owner_id < OWNER_W'(NUM_OWNERS)) begin
                        id_in    = req_data.owner_id;
                        need_in  = req_data.byte_size >> BLOCK_SHIFT;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_SIZE: begin
                     if (req_data.owner_id < OWNER_W'(NUM_OWNERS)) begin
                        sz_we = 1'b1;
                        ok_in = 1'b1;
                     end
                  end
                  ACT_OWNER: begin
                     if (SUM_W'(req_data.block_index) < SUM_W'(NUM_BLOCKS)) begin
                        own_we    = 1'b1;
                        own_waddr = AW'(req_data.block_index);
                        own_wdata = req_data.owner_id;
                        ok_in     = 1'b1;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_SCAN, ST_RUN: begin
            if (own_free) begin
               if (state_ff == ST_SCAN) begin
                  // open a new candidate run at this entry
                  start_in = idx_ff;
                  end_in   = SUM_W'(idx_ff) + SUM_W'(need_ff);
                  if (need_ff == '0) begin
                     ok_in    = 1'b1;
                     off_in   = offset_of(idx_ff);
                     state_in = ST_DONE;
                  end else if (idx_inc >= SUM_W'(idx_ff) + SUM_W'(need_ff)) begin
                     state_in = ST_MARK;
                  end else if (inc_past) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in   = AW'(idx_inc);
                     state_in = ST_RUN;
                  end
               end else begin
                  if (idx_inc >= end_ff) begin
                     idx_in   = start_ff;
                     state_in = ST_MARK;
                  end else if (inc_past) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = AW'(idx_inc);
                  end
               end
            end else if (own_sized) begin
               state_in = ST_SIZE;
            end else if (inc_past) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = AW'(idx_inc);
               state_in = ST_SCAN;
            end
         end

         ST_SIZE: begin
            // skip the occupied run by its owner's recorded size
            if (idx_skip >= SUM_W'(NUM_BLOCKS)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = AW'(idx_skip);
               state_in = ST_SCAN;
            end
         end

         ST_MARK: begin
            own_we = 1'b1;
            if (idx_inc >= end_ff) begin
               ok_in    = 1'b1;
               off_in   = offset_of(start_ff);
               state_in = ST_DONE;
            end else begin
               idx_in = AW'(idx_inc);
            end
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      own_raddr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      need_ff  <= need_in;
      id_ff    <= id_in;
      ok_ff    <= ok_in;
      off_ff   <= off_in;
   end

endmodule

`default_nettype wire
